[hdl/hbbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hbbc_pkg;
    localparam int ENTRY_COUNT_DEF  = 32;
    localparam int BUCKET_COUNT_DEF = 13;
    localparam int DEV_W   = 16;
    localparam int BLK_W   = 32;
    localparam int IDX_W   = 5;
    localparam int STAMP_W = 32;
    localparam int REFS_W  = 8;
    localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_PIN     = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;
endpackage
`default_nettype wire

[hdl/hashed_block_buffer_cache.sv]
`timescale 1ns / 1ps
`default_nettype none
// Hashed buffer cache bookkeeping. Pulse start while busy is low; exactly one
// result appears later for one cycle with done high, and the receiver must
// take it then. Entry fields and links sit in one synchronous memory read
// once per cycle. An ignored request gives its result in the cycle after it
// is accepted, and a release or pin first reads its entry in S_IDX. A get
// walks the home bucket, then, on a miss with no free entry there, every
// entry of the other buckets. The home bucket is found by folding the block
// number bytes with their weights mod BUCKET_COUNT until one byte is left,
// then a constant table. After reset, a clearing pass writes every entry and
// sets up links; busy stays high during it.
module hashed_block_buffer_cache #(
    parameter int ENTRY_COUNT  = hbbc_pkg::ENTRY_COUNT_DEF,
    parameter int BUCKET_COUNT = hbbc_pkg::BUCKET_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic [hbbc_pkg::DEV_W-1:0]   device,
    input  wire logic [hbbc_pkg::BLK_W-1:0]   block_number,
    input  wire logic [hbbc_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [hbbc_pkg::STAMP_W-1:0] now_ticks,
    output logic                              done,
    output logic [hbbc_pkg::IDX_W-1:0]        granted_entry,
    output logic                              was_hit,
    output logic                              needs_fill,
    output logic [1:0]                        status
);
    import hbbc_pkg::*;

    localparam int EW = $clog2(ENTRY_COUNT + 1);      // holds null
    localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SW = EW + 1;
    localparam logic [EW-1:0] LNULL = EW'(ENTRY_COUNT);
    localparam logic [BW-1:0] BLAST = BW'(BUCKET_COUNT - 1);
    localparam logic [AW-1:0] ALAST = AW'(ENTRY_COUNT - 1);
    localparam logic [SW-1:0] SLIM  = SW'(ENTRY_COUNT);
    // byte weights: 2^8, 2^16 and 2^24 mod the bucket count
    localparam logic [15:0] FW1 = 16'(256 % BUCKET_COUNT);
    localparam logic [15:0] FW2 = 16'(65536 % BUCKET_COUNT);
    localparam logic [15:0] FW3 = 16'(((65536 % BUCKET_COUNT) * 256) % BUCKET_COUNT);

    function automatic logic [256*BW-1:0] home_table();
        logic [256*BW-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++)
        begin
            t[i*BW +: BW] = BW'(i % BUCKET_COUNT);
        end
        return t;
    endfunction

    localparam logic [256*BW-1:0] HOME_LUT = home_table();

    typedef struct packed {
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   blk;
        logic               vld;
        logic [REFS_W-1:0]  refs;
        logic [STAMP_W-1:0] stamp;
        logic [EW-1:0]      link;
    } slot_t;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_MOD    = 13'b0000000000100,
        S_HHEAD  = 13'b0000000001000,
        S_HRD    = 13'b0000000010000,
        S_HCHK   = 13'b0000000100000,
        S_FREE   = 13'b0000001000000,
        S_OHEAD  = 13'b0000010000000,
        S_ORD    = 13'b0000100000000,
        S_OCHK   = 13'b0001000000000,
        S_UNLINK = 13'b0010000000000,
        S_APPEND = 13'b0100000000000,
        S_IDX    = 13'b1000000000000
    } state_t;

    slot_t         mem [ENTRY_COUNT];
    logic [EW-1:0] first_reg [BUCKET_COUNT];
    slot_t         rd_q;

    state_t state_reg, state_next;
    logic            mwe;
    logic [AW-1:0]   mwa, mra;
    slot_t           mwd;
    logic            fwe;
    logic [BW-1:0]   fwa;
    logic [EW-1:0]   fwd;

    logic [1:0]         req_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [BLK_W-1:0]   fold_reg, fold_next;
    logic [BW-1:0]      home_reg, home_next, bk_reg, bk_next;
    logic [EW-1:0]      cur_reg, cur_next, tail_reg, tail_next, free_reg, free_next;
    logic [EW-1:0]      prev_reg, prev_next, best_reg, best_next, bprev_reg, bprev_next;
    logic [BW-1:0]      bbk_reg, bbk_next;
    logic               found_reg, found_next;
    logic [STAMP_W-1:0] old_reg, old_next;
    logic [SW-1:0]      steps_reg, steps_next;
    logic [EW-1:0]      blink_reg, blink_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               done_next;
    logic [IDX_W-1:0]   ge_next;
    logic               hit_next, fill_next;
    logic [1:0]         st_next;
    logic [15:0]        fold_sum;
    logic [BW-1:0]      home_lut;

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mem[mwa] <= mwd;
        end
        rd_q <= mem[mra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKET_COUNT; i++)
            begin
                first_reg[i] <= (i == 0) ? EW'(0) : LNULL;
            end
        end
        else if (fwe)
        begin
            first_reg[fwa] <= fwd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mwe = 1'b0; mwa = cur_reg[AW-1:0]; mwd = rd_q; mra = cur_reg[AW-1:0];
        fwe = 1'b0; fwa = bk_reg; fwd = LNULL;
        fold_next = fold_reg; home_next = home_reg; bk_next = bk_reg;
        cur_next = cur_reg; tail_next = tail_reg; free_next = free_reg;
        prev_next = prev_reg; best_next = best_reg; bprev_next = bprev_reg;
        bbk_next = bbk_reg; found_next = found_reg; old_next = old_reg;
        steps_next = steps_reg; blink_next = blink_reg; clr_next = clr_reg;
        done_next = 1'b0; ge_next = granted_entry; hit_next = 1'b0;
        fill_next = 1'b0; st_next = ST_OK;
        fold_sum = 16'(fold_reg[7:0]) + 16'(fold_reg[15:8]) * FW1
                 + 16'(fold_reg[23:16]) * FW2 + 16'(fold_reg[31:24]) * FW3;
        home_lut = HOME_LUT[int'(fold_reg[7:0]) * BW +: BW];
        unique case (state_reg)
            S_CLEAR:
            begin
                mwe = 1'b1; mwa = clr_reg;
                mwd = '0;
                mwd.link = (clr_reg == ALAST) ? LNULL : EW'(clr_reg) + EW'(1);
                clr_next = clr_reg + AW'(1);
                if (clr_reg == ALAST) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_GET)
                    begin
                        fold_next = block_number; state_next = S_MOD;
                    end
                    else if (req_type == REQ_NONE
                             || 32'(entry_index) >= 32'(ENTRY_COUNT))
                    begin
                        done_next = 1'b1; ge_next = entry_index;
                    end
                    else
                    begin
                        cur_next = EW'(entry_index); state_next = S_IDX;
                        mra = AW'(entry_index);
                    end
                end
            end
            S_IDX:
            begin
                done_next = 1'b1; ge_next = idx_reg; state_next = S_IDLE;
                if (req_reg == REQ_RELEASE)
                begin
                    if (rd_q.refs == '0) st_next = ST_UNDERFLOW;
                    else begin mwe = 1'b1; mwd.refs = rd_q.refs - REFS_W'(1); end
                end
                else if (rd_q.refs == REFS_MAX) st_next = ST_OVERFLOW;
                else begin mwe = 1'b1; mwd.refs = rd_q.refs + REFS_W'(1); end
            end
            S_MOD:
            begin
                // weighted byte fold keeps the value mod the bucket count
                if (fold_reg[BLK_W-1:8] == '0) state_next = S_HHEAD;
                else fold_next = {16'b0, fold_sum};
            end
            S_HHEAD:
            begin
                home_next = home_lut;
                cur_next = first_reg[home_lut];
                tail_next = LNULL; free_next = LNULL; steps_next = '0;
                state_next = S_HRD;
            end
            S_HRD:
            begin
                if (cur_reg >= LNULL || steps_reg >= SLIM) state_next = S_FREE;
                else state_next = S_HCHK;
            end
            S_HCHK:
            begin
                if (rd_q.dev == dev_reg && rd_q.blk == blk_reg)
                begin
                    done_next = 1'b1; hit_next = 1'b1;
                    ge_next = IDX_W'(cur_reg); state_next = S_IDLE;
                    if (rd_q.refs == REFS_MAX) st_next = ST_OVERFLOW;
                    else
                    begin
                        mwe = 1'b1; mwd.stamp = rd_q.stamp + STAMP_W'(1);
                        mwd.refs = rd_q.refs + REFS_W'(1); mwd.vld = 1'b1;
                        fill_next = ~rd_q.vld;
                    end
                end
                else
                begin
                    if (rd_q.refs == '0) free_next = cur_reg;
                    tail_next = cur_reg; cur_next = rd_q.link;
                    steps_next = steps_reg + SW'(1); state_next = S_HRD;
                end
            end
            S_FREE:
            begin
                if (free_reg < LNULL)
                begin
                    cur_next = free_reg; mra = free_reg[AW-1:0];
                    state_next = S_APPEND;   // read for assign, no relink
                    best_next = LNULL;
                end
                else
                begin
                    bk_next = '0; found_next = 1'b0; best_next = LNULL;
                    state_next = S_OHEAD;
                end
            end
            S_OHEAD:
            begin
                if (bk_reg == home_reg)
                begin
                    if (bk_reg == BLAST) begin state_next = S_UNLINK; steps_next = '0; end
                    else bk_next = bk_reg + BW'(1);
                end
                else
                begin
                    cur_next = first_reg[bk_reg]; prev_next = LNULL;
                    steps_next = '0; state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                if (cur_reg >= LNULL || steps_reg >= SLIM)
                begin
                    if (bk_reg == BLAST) begin state_next = S_UNLINK; steps_next = '0; end
                    else begin bk_next = bk_reg + BW'(1); state_next = S_OHEAD; end
                end
                else state_next = S_OCHK;
            end
            S_OCHK:
            begin
                if (rd_q.refs == '0 && (!found_reg || rd_q.stamp < old_reg))
                begin
                    found_next = 1'b1; old_next = rd_q.stamp; best_next = cur_reg;
                    bprev_next = prev_reg; bbk_next = bk_reg; blink_next = rd_q.link;
                end
                prev_next = cur_reg; cur_next = rd_q.link;
                steps_next = steps_reg + SW'(1); state_next = S_ORD;
            end
            S_UNLINK:
            begin
                if (!found_reg)
                begin
                    done_next = 1'b1; ge_next = '0; st_next = ST_NO_FREE;
                    state_next = S_IDLE;
                end
                else
                begin
                    // bypass the stolen entry, then hook it to the home tail
                    if (bprev_reg < LNULL)
                    begin
                        mwe = 1'b1; mwa = bprev_reg[AW-1:0];
                        mwd = rd_q; mra = bprev_reg[AW-1:0];
                        if (steps_reg == '0) mwe = 1'b0;
                        else mwd.link = blink_reg;
                        steps_next = (steps_reg == '0) ? SW'(1) : '0;
                        if (steps_reg != '0) state_next = S_APPEND;
                    end
                    else
                    begin
                        fwe = 1'b1; fwa = bbk_reg; fwd = blink_reg;
                        state_next = S_APPEND; steps_next = '0;
                    end
                    if (state_next == S_APPEND)
                    begin
                        cur_next = tail_reg < LNULL ? tail_reg : best_reg;
                        mra = cur_next[AW-1:0];
                    end
                end
            end
            S_APPEND:
            begin
                // cur holds the entry just read: tail (steal) or granted entry
                if (best_reg < LNULL && tail_reg < LNULL && cur_reg == tail_reg
                    && steps_reg == '0)
                begin
                    mwe = 1'b1; mwa = tail_reg[AW-1:0]; mwd = rd_q;
                    mwd.link = best_reg; steps_next = SW'(1);
                    cur_next = best_reg; mra = best_reg[AW-1:0];
                end
                else if (steps_reg == '0 && best_reg < LNULL && tail_reg >= LNULL)
                begin
                    fwe = 1'b1; fwa = home_reg; fwd = best_reg;
                    steps_next = SW'(1);
                    mra = best_reg[AW-1:0];
                end
                else if (steps_reg == '0 && best_reg >= LNULL)
                begin
                    steps_next = SW'(1);   // plain reuse, data already read
                    mra = cur_reg[AW-1:0];
                end
                else
                begin
                    mwe = 1'b1; mwa = cur_reg[AW-1:0];
                    mwd.dev = dev_reg; mwd.blk = blk_reg; mwd.vld = 1'b1;
                    mwd.refs = REFS_W'(1); mwd.stamp = now_reg;
                    mwd.link = (best_reg < LNULL) ? LNULL : rd_q.link;
                    done_next = 1'b1; fill_next = 1'b1; ge_next = IDX_W'(cur_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR; clr_reg <= '0; done <= 1'b0;
            steps_reg <= '0; found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; clr_reg <= clr_next; done <= done_next;
            steps_reg <= state_reg == S_FREE ? '0 : steps_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req_type; dev_reg <= device; blk_reg <= block_number;
            idx_reg <= entry_index; now_reg <= now_ticks;
        end
        fold_reg <= fold_next; home_reg <= home_next;
        bk_reg <= bk_next; cur_reg <= cur_next; tail_reg <= tail_next;
        free_reg <= free_next; prev_reg <= prev_next; best_reg <= best_next;
        bprev_reg <= bprev_next; bbk_reg <= bbk_next; old_reg <= old_next;
        blink_reg <= blink_next;
        granted_entry <= ge_next; was_hit <= hit_next;
        needs_fill <= fill_next; status <= st_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_NO_FREE |-> granted_entry == '0 && !needs_fill)
        else $error("no-free result with entry");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("result while working");
    a_hit_nofree: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_hit |-> status != ST_NO_FREE) else $error("hit flagged no free");
    a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && needs_fill |-> status == ST_OK) else $error("fill with error");
endmodule
`default_nettype wire

[verif/tb_hashed_block_buffer_cache.sv]
`timescale 1ns / 1ps
module tb_hashed_block_buffer_cache;
    import hbbc_pkg::*;

    localparam int NENT = ENTRY_COUNT_DEF;
    localparam int NBKT = BUCKET_COUNT_DEF;
    localparam int LNULL = NENT;
    localparam int RANDOM_WORDS = 528;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IDX_W-1:0] entry;
        logic             hit;
        logic             fill;
        status_t          st;
    } cache_reply_t;

    typedef struct {
        req_t             req;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        logic [31:0]      now;
        bit               fixed;
        cache_reply_t     reply;
    } cache_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] req_type = '0;
    logic [DEV_W-1:0] device = '0;
    logic [BLK_W-1:0] block_number = '0;
    logic [IDX_W-1:0] entry_index = '0;
    logic [STAMP_W-1:0] now_ticks = '0;
    wire busy, done, was_hit, needs_fill;
    wire [IDX_W-1:0] granted_entry;
    wire [1:0] status;

    hashed_block_buffer_cache uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .device(device), .block_number(block_number),
        .entry_index(entry_index), .now_ticks(now_ticks), .done(done),
        .granted_entry(granted_entry), .was_hit(was_hit),
        .needs_fill(needs_fill), .status(status)
    );

    always #5 clk = ~clk;

    // shadow copy of the cache bookkeeping
    logic [DEV_W-1:0] sh_dev [NENT];
    logic [BLK_W-1:0] sh_blk [NENT];
    logic             sh_valid [NENT];
    logic [REFS_W-1:0] sh_refs [NENT];
    logic [31:0]      sh_stamp [NENT];
    int               sh_link [NENT];
    int               sh_first [NBKT];

    cache_reply_t pending_replies [$];
    int errors = 0;
    int gets_seen = 0, hits_seen = 0, steals_seen = 0, nofree_seen = 0;
    longint cycles = 0;

    function automatic cache_reply_t mk(int e, bit h, bit f, status_t s);
        cache_reply_t r;
        r.entry = e[IDX_W-1:0];
        r.hit = h;
        r.fill = f;
        r.st = s;
        return r;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < NENT; i++)
        begin
            sh_dev[i] = '0; sh_blk[i] = '0; sh_valid[i] = 1'b0;
            sh_refs[i] = '0; sh_stamp[i] = '0;
            sh_link[i] = (i + 1 < NENT) ? i + 1 : LNULL;
        end
        for (int b = 0; b < NBKT; b++)
            sh_first[b] = LNULL;
        sh_first[0] = 0;
    endfunction

    function automatic void claim(int e, logic [DEV_W-1:0] d, logic [BLK_W-1:0] k,
                                  logic [31:0] n);
        sh_dev[e] = d; sh_blk[e] = k; sh_valid[e] = 1'b1;
        sh_refs[e] = REFS_W'(1); sh_stamp[e] = n;
    endfunction

    function automatic cache_reply_t lookup_block(logic [DEV_W-1:0] d,
                                                  logic [BLK_W-1:0] k, logic [31:0] n);
        int home, cur, tail, free_e, best, best_prev, best_bkt, prev;
        longint oldest;
        cache_reply_t r;
        home = int'(k % NBKT);
        tail = LNULL; free_e = LNULL; best = LNULL; best_prev = LNULL; best_bkt = 0;
        oldest = 64'h7fff_ffff_ffff_ffff;
        gets_seen++;
        cur = sh_first[home];
        for (int s = 0; cur < NENT && s < NENT; s++)
        begin
            if (sh_dev[cur] == d && sh_blk[cur] == k)
            begin
                hits_seen++;
                if (sh_refs[cur] >= REFS_MAX)
                    return mk(cur, 1, 0, ST_OVERFLOW);
                sh_stamp[cur]++;
                sh_refs[cur]++;
                r = mk(cur, 1, !sh_valid[cur], ST_OK);
                sh_valid[cur] = 1'b1;
                return r;
            end
            if (sh_refs[cur] == 0)
                free_e = cur;
            tail = cur;
            cur = sh_link[cur];
        end
        if (free_e < NENT)
        begin
            claim(free_e, d, k, n);
            return mk(free_e, 0, 1, ST_OK);
        end
        for (int b = 0; b < NBKT; b++)
        begin
            if (b == home)
                continue;
            prev = LNULL;
            cur = sh_first[b];
            for (int s = 0; cur < NENT && s < NENT; s++)
            begin
                if (sh_refs[cur] == 0 && longint'(sh_stamp[cur]) < oldest)
                begin
                    oldest = longint'(sh_stamp[cur]); best = cur; best_prev = prev;
                    best_bkt = b;
                end
                prev = cur;
                cur = sh_link[cur];
            end
        end
        if (best >= NENT)
        begin
            nofree_seen++;
            return mk(0, 0, 0, ST_NO_FREE);
        end
        steals_seen++;
        if (best_prev < NENT)
            sh_link[best_prev] = sh_link[best];
        else
            sh_first[best_bkt] = sh_link[best];
        sh_link[best] = LNULL;
        if (tail < NENT)
            sh_link[tail] = best;
        else
            sh_first[home] = best;
        claim(best, d, k, n);
        return mk(best, 0, 1, ST_OK);
    endfunction

    function automatic cache_reply_t predict_reply(cache_word_t w);
        int i;
        i = int'(w.idx);
        if (w.req == REQ_GET)
            return lookup_block(w.dev, w.blk, w.now);
        if (w.req == REQ_NONE || i >= NENT)
            return mk(i, 0, 0, ST_OK);
        if (w.req == REQ_RELEASE)
        begin
            if (sh_refs[i] == 0)
                return mk(i, 0, 0, ST_UNDERFLOW);
            sh_refs[i]--;
        end
        else
        begin
            if (sh_refs[i] >= REFS_MAX)
                return mk(i, 0, 0, ST_OVERFLOW);
            sh_refs[i]++;
        end
        return mk(i, 0, 0, ST_OK);
    endfunction

    // results are taken at the edge that ends the done cycle
    always @(posedge clk)
    begin
        cache_reply_t exp_r;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with nothing expected: entry %0d", granted_entry);
                errors++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (granted_entry !== exp_r.entry)
                begin
                    $error("granted_entry exp %0d got %0d", exp_r.entry, granted_entry);
                    errors++;
                end
                if (was_hit !== exp_r.hit)
                begin
                    $error("was_hit exp %0d got %0d", exp_r.hit, was_hit);
                    errors++;
                end
                if (needs_fill !== exp_r.fill)
                begin
                    $error("needs_fill exp %0d got %0d", exp_r.fill, needs_fill);
                    errors++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status exp %0d got %0d", exp_r.st, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    bit allow_gaps = 1;

    // hands one word to the block and lowers start again before the next word
    task automatic send_word(cache_word_t w);
        cache_reply_t r;
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= w.req;
        device <= w.dev;
        block_number <= w.blk;
        entry_index <= w.idx;
        now_ticks <= w.now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_reply(w);
        if (w.fixed && r !== w.reply)
        begin
            $error("table row disagrees: entry exp %0d got %0d, status exp %0d got %0d",
                   w.reply.entry, r.entry, w.reply.st, r.st);
            errors++;
        end
        pending_replies.push_back(r);
        start <= 1'b0;
        @(posedge clk);
        while (busy && !done)
            @(posedge clk);
    endtask

    function automatic cache_word_t row(req_t q, int d, logic [31:0] k, int i,
                                        logic [31:0] n, bit f, cache_reply_t r);
        cache_word_t w;
        w.req = q; w.dev = d[DEV_W-1:0]; w.blk = k; w.idx = i[IDX_W-1:0];
        w.now = n; w.fixed = f; w.reply = r;
        return w;
    endfunction

    cache_word_t directed [$];
    cache_reply_t nr;
    logic [31:0] hot_blk [8];
    logic [DEV_W-1:0] hot_dev [8];

    initial
    begin
        cache_word_t w;
        int kind;
        shadow_reset();
        nr = mk(0, 0, 0, ST_OK);
        // after reset: entries 0..31 all in bucket 0, all free
        directed.push_back(row(REQ_RELEASE, 0, 0, 0, 0, 1, mk(0, 0, 0, ST_UNDERFLOW)));
        directed.push_back(row(REQ_NONE, 16'hffff, '1, 31, '1, 1, mk(31, 0, 0, ST_OK)));
        directed.push_back(row(REQ_GET, 0, 0, 0, 32'h5, 1, mk(0, 1, 1, ST_OK)));
        directed.push_back(row(REQ_GET, 0, 0, 7, 32'h9, 1, mk(0, 1, 0, ST_OK)));
        directed.push_back(row(REQ_GET, 16'hffff, 32'hffff_ffff, 0, '1, 0, nr));
        directed.push_back(row(REQ_GET, 16'h1234, 32'd13, 0, 32'd0, 0, nr));
        directed.push_back(row(REQ_GET, 16'h1234, 32'd13, 0, 32'd0, 0, nr));
        directed.push_back(row(REQ_PIN, 0, 0, 31, 0, 1, mk(31, 0, 0, ST_OK)));
        directed.push_back(row(REQ_RELEASE, 0, 0, 31, 0, 1, mk(31, 0, 0, ST_OK)));
        directed.push_back(row(REQ_RELEASE, 0, 0, 31, 0, 1, mk(31, 0, 0, ST_OK)));
        directed.push_back(row(REQ_RELEASE, 0, 0, 31, 0, 1, mk(31, 0, 0, ST_OK)));
        directed.push_back(row(REQ_NONE, 0, 0, 0, 0, 1, mk(0, 0, 0, ST_OK)));
        // pin one entry to the top to reach count overflow on pin
        for (int p = 0; p < 256; p++)
            directed.push_back(row(REQ_PIN, 0, 0, 5, 0, 0, nr));
        for (int b = 1; b <= 4; b++)
            directed.push_back(row(REQ_GET, 16'h00aa, b, 0, 32'd100 - b, 0, nr));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[j])
            send_word(directed[j]);

        // fill the cache from one hot set of blocks, mixed with random gets, releases, pins and ignored words
        for (int h = 0; h < 8; h++)
        begin
            hot_blk[h] = $urandom();
            hot_dev[h] = DEV_W'($urandom_range(0, 3));
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n > RANDOM_WORDS - 100)
                allow_gaps = 0;
            kind = $urandom_range(0, 99);
            w = row(REQ_GET, 0, 0, 0, $urandom(), 0, nr);
            w.idx = IDX_W'($urandom());
            if (kind < 40)
            begin
                w.dev = hot_dev[$urandom_range(0, 7)];
                w.blk = hot_blk[$urandom_range(0, 7)] + $urandom_range(0, 3);
            end
            else if (kind < 55)
            begin
                w.dev = DEV_W'($urandom());
                w.blk = $urandom();
            end
            else if (kind < 78)
                w.req = REQ_RELEASE;
            else if (kind < 96)
                w.req = REQ_PIN;
            else
            begin
                w.req = REQ_NONE;
                w.dev = DEV_W'($urandom());
                w.blk = $urandom();
            end
            send_word(w);
        end

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d gets: %0d hits, %0d steals from other buckets, %0d no-free",
                 gets_seen, hits_seen, steals_seen, nofree_seen);
        if (errors == 0 && pending_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[sim.f]
hdl/hbbc_pkg.sv
hdl/hashed_block_buffer_cache.sv
verif/tb_hashed_block_buffer_cache.sv
